>>> rtl/assert_macros.svh
// Assertion macros for the RTL files, used by the queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

>>> rtl/smpq_pkg.sv
// Types and constants of the stable minimum priority queue.
`timescale 1ns / 1ps
package smpq_pkg;

	localparam int DEPTH = 16;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_value;
		logic signed [15:0] item_rank;
	} req_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
	} rsp_item_t;

	typedef struct packed {
		logic               occ;
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	typedef struct packed {
		logic               ins;
		logic               del;
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} cell_ctrl_t;

endpackage

>>> rtl/smpq_cell.sv
// One queue cell: holds an entry and shifts toward or away from the front.
`timescale 1ns / 1ps
module smpq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  smpq_pkg::cell_ctrl_t ctrl,
	input  smpq_pkg::entry_t   prev_entry,
	input  logic               prev_stay,
	input  smpq_pkg::entry_t   next_entry,
	output smpq_pkg::entry_t   entry,
	output logic               stay
);
	import smpq_pkg::*;

	logic               occ_q;
	logic signed [31:0] value_q;
	logic signed [15:0] prio_q;

	assign entry = '{occ: occ_q, value: value_q, prio: prio_q};
	assign stay  = occ_q && ($signed(prio_q) <= $signed(ctrl.prio));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.ins && !stay) begin
			occ_q <= prev_stay ? 1'b1 : prev_entry.occ;
		end else if (ctrl.del) begin
			occ_q <= next_entry.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !stay) begin
			if (prev_stay) begin
				value_q <= ctrl.value;
				prio_q  <= ctrl.prio;
			end else begin
				value_q <= prev_entry.value;
				prio_q  <= prev_entry.prio;
			end
		end else if (ctrl.del) begin
			value_q <= next_entry.value;
			prio_q  <= next_entry.prio;
		end
	end

endmodule

>>> rtl/stable_min_priority_queue_unit.sv
// Top level of the stable minimum priority queue: a row of sorted cells.
//
//   channel  direction  payload     handshake
//   req      in         req_item_t  req_valid / req_stall
//   rsp      out        rsp_item_t  rsp_valid / rsp_stall
//
// One item per cycle while req_stall is low: every cell compares, and cells shift in the cycle of the transfer.
// The result is registered and appears the cycle after the request transfer.
// Reset empties the queue at once; no clearing pass.
// A held result stalls the request side only while rsp_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stable_min_priority_queue_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  smpq_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output smpq_pkg::rsp_item_t rsp
);
	import smpq_pkg::*;

	entry_t            cells [DEPTH];
	logic [DEPTH-1:0]  stay;
	logic [DEPTH-1:0]  occ;
	cell_ctrl_t        ctrl;
	logic              acc;
	logic              full;
	logic              empty;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;
	entry_t            no_entry;

	assign no_entry  = '{occ: 1'b0, value: '0, prio: '0};
	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign full      = occ[DEPTH-1];
	assign empty     = !occ[0];

	assign ctrl.ins   = acc && (req.kind == KIND_INSERT) && !full;
	assign ctrl.del   = acc && (req.kind == KIND_DELETE) && !empty;
	assign ctrl.value = req.item_value;
	assign ctrl.prio  = req.item_rank;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i] = cells[i].occ;
		smpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry ((i == 0) ? no_entry : cells[(i == 0) ? 0 : i - 1]),
			.prev_stay  ((i == 0) ? 1'b1 : stay[(i == 0) ? 0 : i - 1]),
			.next_entry ((i == DEPTH - 1) ? no_entry : cells[(i == DEPTH - 1) ? i : i + 1]),
			.entry      (cells[i]),
			.stay       (stay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			if (req.kind == KIND_DELETE) begin
				rsp_q.status        <= empty ? ST_UNDERFLOW : ST_DONE;
				rsp_q.removed_value <= empty ? INT_MIN : cells[0].value;
			end else begin
				rsp_q.status        <= full ? ST_FULL : ST_DONE;
				rsp_q.removed_value <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_SAME(a_occ_thermo, 1'b1, ((occ + DEPTH'(1)) & occ) == '0)
	`ASSERT_NEXT(a_rsp_after_transfer, acc, rsp_valid)
	`ASSERT_NEXT(a_underflow, acc && req.kind == KIND_DELETE && empty, rsp.status == ST_UNDERFLOW)
	`ASSERT_NEXT(a_full_drop, acc && req.kind == KIND_INSERT && full, $stable(occ))

endmodule
